FILE: hdl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg: shared types and helpers for the anchored transform composer
// Fixed-point types for Q16.16 positions, binary angles and Q2.30 sines,
// plus the pipeline depth and the saturation helper.
// ----------------------------------------------------------------------------
package atc_pkg;

    // Signed Q16.16 position or depth
    typedef logic signed [31:0] q16_t;

    // Binary angle, 65536 units per turn
    typedef logic [15:0] bam_t;

    // Signed Q2.30 sine or cosine
    typedef logic signed [31:0] q30_t;

    // Rotated coordinate before the final sum, Q16.16 with two guard bits
    typedef logic signed [33:0] rot_t;

    // Position sum before saturation
    typedef logic signed [35:0] wide_t;

    // Quarter turn, the cosine offset
    localparam bam_t QUARTER_TURN = 16'h4000;

    // Register stages from input to output
    localparam int unsigned STAGES = 8;

    // Stages inside the sine pipeline
    localparam int unsigned SINE_STAGES = 4;

    // Rounding bias for a divide by 2^30, ties up
    localparam logic signed [65:0] Q30_HALF = 66'sd536870912;

    // Limits of a signed 32-bit Q16.16 value
    localparam wide_t Q16_MAX = 36'sd2147483647;
    localparam wide_t Q16_MIN = -36'sd2147483648;

    // Clamp a wide sum to the signed 32-bit range
    function automatic q16_t sat_q16(input wide_t v);
        q16_t res;
        if (v > Q16_MAX)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (v < Q16_MIN)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/atc_if.sv
// ----------------------------------------------------------------------------
// atc_if: valid/ready channels of the anchored transform composer
// One interface for the input transaction (parent and local transform) and
// one for the result transaction (world transform).
// ----------------------------------------------------------------------------
interface atc_item_if;
    logic            valid;
    logic            ready;
    atc_pkg::q16_t   parent_x;
    atc_pkg::q16_t   parent_y;
    atc_pkg::bam_t   parent_angle;
    atc_pkg::q16_t   parent_depth;
    atc_pkg::q16_t   local_x;
    atc_pkg::q16_t   local_y;
    atc_pkg::q16_t   anchor_x;
    atc_pkg::q16_t   anchor_y;
    atc_pkg::bam_t   local_angle;
    atc_pkg::q16_t   local_depth;

    modport source
    (
        output valid, parent_x, parent_y, parent_angle, parent_depth,
               local_x, local_y, anchor_x, anchor_y, local_angle, local_depth,
        input  ready
    );

    modport sink
    (
        input  valid, parent_x, parent_y, parent_angle, parent_depth,
               local_x, local_y, anchor_x, anchor_y, local_angle, local_depth,
        output ready
    );
endinterface

interface atc_result_if;
    logic            valid;
    logic            ready;
    atc_pkg::q16_t   world_x;
    atc_pkg::q16_t   world_y;
    atc_pkg::bam_t   world_angle;
    atc_pkg::q16_t   world_depth;

    modport source
    (
        output valid, world_x, world_y, world_angle, world_depth,
        input  ready
    );

    modport sink
    (
        input  valid, world_x, world_y, world_angle, world_depth,
        output ready
    );
endinterface

FILE: hdl/atc_sine.sv
// ----------------------------------------------------------------------------
// atc_sine: four-stage pipelined sine of a binary angle
// Folds the angle into the first quadrant and evaluates an integer odd
// polynomial, one multiply per stage, giving a signed Q2.30 result.
// ----------------------------------------------------------------------------
module atc_sine
(
    input  logic                                 clk,
    input  logic [atc_pkg::SINE_STAGES-1:0]      adv,
    input  atc_pkg::bam_t                        angle,
    output atc_pkg::q30_t                        sine
);

    // Polynomial coefficients: A, B = 2A - 5*2^29, C = A - 3*2^29
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;
    localparam logic [14:0] R_QUARTER = 15'd16384;

    // Stage a: folded angle and its square
    logic [14:0] r_a_reg;
    logic [30:0] z2_a_reg;
    logic        neg_a_reg;

    // Stage b: inner term
    logic [14:0] r_b_reg;
    logic [30:0] z2_b_reg;
    logic [29:0] t1_b_reg;
    logic        neg_b_reg;

    // Stage c: outer term
    logic [14:0] r_c_reg;
    logic [30:0] t2_c_reg;
    logic        neg_c_reg;

    // Stage d: signed result
    atc_pkg::q30_t sine_reg;

    logic [14:0] r_next;
    logic [30:0] z2_next;
    logic [29:0] t1_next;
    logic [30:0] t2_next;
    atc_pkg::q30_t sine_next;

    // Fold into the first quadrant and square
    always_comb
    begin
        logic [14:0] r_raw;
        logic [29:0] sq;
        r_raw = {1'b0, angle[13:0]};
        r_next = angle[14] ? (R_QUARTER - r_raw) : r_raw;
        sq = 30'(r_next) * 30'(r_next);
        z2_next = {sq[28:0], 2'b00};
    end

    // Inner term: B - (C * z2) >> 30
    always_comb
    begin
        logic [57:0] cz;
        cz = 58'(SIN_C) * 58'(z2_a_reg);
        t1_next = SIN_B - 30'(cz[57:30]);
    end

    // Outer term: A - (t1 * z2) >> 30
    always_comb
    begin
        logic [60:0] tz;
        tz = 61'(t1_b_reg) * 61'(z2_b_reg);
        t2_next = SIN_A - tz[60:30];
    end

    // Final product: (t2 * (r << 16)) >> 30, then apply the half-turn sign
    always_comb
    begin
        logic [45:0] tr;
        atc_pkg::q30_t mag;
        tr = 46'(t2_c_reg) * 46'(r_c_reg);
        mag = signed'({1'b0, tr[44:14]});
        sine_next = neg_c_reg ? -mag : mag;
    end

    // Advance each stage on its own enable
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r_a_reg   <= r_next;
            z2_a_reg  <= z2_next;
            neg_a_reg <= angle[15];
        end
        if (adv[1])
        begin
            r_b_reg   <= r_a_reg;
            z2_b_reg  <= z2_a_reg;
            t1_b_reg  <= t1_next;
            neg_b_reg <= neg_a_reg;
        end
        if (adv[2])
        begin
            r_c_reg   <= r_b_reg;
            t2_c_reg  <= t2_next;
            neg_c_reg <= neg_b_reg;
        end
        if (adv[3])
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

FILE: hdl/anchored_transform_compose_core.sv
// ----------------------------------------------------------------------------
// anchored_transform_compose_core: world transform of a child node
// Adds angles and depths, rotates the local offset by the parent angle and
// the anchor by the world angle, and sums the positions with saturation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Carries
//  item     in         valid/ready   parent and local transform, anchor
//  result   out        valid/ready   world position, angle and depth
//
//  Throughput is one transaction per cycle while the result is not stalled;
//  the pipe is 8 register stages: capture, the four-multiply sine pipeline
//  and the rotate, round and sum stages.
//  Reset clears the stage valid bits and the occupancy counter; payload registers are not reset.
//  A stage holds while the stage after it is full and not advancing, so a
//  stalled result keeps the pipe full and empty stages still collapse.
//
module anchored_transform_compose_core
(
    input  logic               clk,
    input  logic               rst_n,
    atc_item_if.sink           item,
    atc_result_if.source       result
);

    localparam int unsigned NS = atc_pkg::STAGES;

    // Payload carried alongside the sine pipeline
    typedef struct packed {
        atc_pkg::q16_t px;
        atc_pkg::q16_t py;
        atc_pkg::q16_t lx;
        atc_pkg::q16_t ly;
        atc_pkg::q16_t ax;
        atc_pkg::q16_t ay;
        atc_pkg::bam_t pa;
        atc_pkg::bam_t wa;
        atc_pkg::q16_t wd;
    } carry_t;

    // Stage valid bits and load enables
    logic [NS:1] valid_reg;
    logic [NS:1] adv;

    // Stages 1 through 5: input capture and sine latency
    carry_t carry_reg [1:5];

    // Sines and cosines of the parent and world angles
    atc_pkg::q30_t sin_p;
    atc_pkg::q30_t cos_p;
    atc_pkg::q30_t sin_w;
    atc_pkg::q30_t cos_w;

    // Stage 6: products
    logic signed [63:0] lx_cp_reg, ly_sp_reg, lx_sp_reg, ly_cp_reg;
    logic signed [63:0] ax_cw_reg, ay_sw_reg, ax_sw_reg, ay_cw_reg;
    atc_pkg::q16_t px6_reg, py6_reg, wd6_reg;
    atc_pkg::bam_t wa6_reg;

    // Stage 7: rounded rotated terms
    atc_pkg::rot_t ox_reg, oy_reg, nx_reg, ny_reg;
    atc_pkg::q16_t px7_reg, py7_reg, wd7_reg;
    atc_pkg::bam_t wa7_reg;

    // Stage 8: output register
    atc_pkg::q16_t wx_reg, wy_reg, wd8_reg;
    atc_pkg::bam_t wa8_reg;

    carry_t        carry_next;
    atc_pkg::rot_t ox_next, oy_next, nx_next, ny_next;
    atc_pkg::q16_t wx_next, wy_next;

    // Transaction counter for the occupancy check
    logic [3:0] occ_reg;
    logic [3:0] occ_next;

    // Ready ripples back from the output: a stage loads when it is empty
    // or when its contents move on
    always_comb
    begin
        adv[NS] = !valid_reg[NS] || result.ready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k + 1];
        end
    end

    assign item.ready = adv[1];

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= item.valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // Stage 1: capture, add angles, add and clamp depths
    always_comb
    begin
        atc_pkg::wide_t dsum;
        dsum = atc_pkg::wide_t'(item.parent_depth) + atc_pkg::wide_t'(item.local_depth);
        carry_next.px = item.parent_x;
        carry_next.py = item.parent_y;
        carry_next.lx = item.local_x;
        carry_next.ly = item.local_y;
        carry_next.ax = item.anchor_x;
        carry_next.ay = item.anchor_y;
        carry_next.pa = item.parent_angle;
        carry_next.wa = item.parent_angle + item.local_angle;
        carry_next.wd = atc_pkg::sat_q16(dsum);
    end

    // Hold the payload beside the sine pipeline
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            carry_reg[1] <= carry_next;
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (adv[k])
            begin
                carry_reg[k] <= carry_reg[k - 1];
            end
        end
    end

    // Sine pipelines, stages 2 through 5
    atc_sine u_sin_p
    (
        .clk   (clk),
        .adv   (adv[5:2]),
        .angle (carry_reg[1].pa),
        .sine  (sin_p)
    );

    atc_sine u_cos_p
    (
        .clk   (clk),
        .adv   (adv[5:2]),
        .angle (carry_reg[1].pa + atc_pkg::QUARTER_TURN),
        .sine  (cos_p)
    );

    atc_sine u_sin_w
    (
        .clk   (clk),
        .adv   (adv[5:2]),
        .angle (carry_reg[1].wa),
        .sine  (sin_w)
    );

    atc_sine u_cos_w
    (
        .clk   (clk),
        .adv   (adv[5:2]),
        .angle (carry_reg[1].wa + atc_pkg::QUARTER_TURN),
        .sine  (cos_w)
    );

    // Stage 6: one 32x32 product per term
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            lx_cp_reg <= carry_reg[5].lx * cos_p;
            ly_sp_reg <= carry_reg[5].ly * sin_p;
            lx_sp_reg <= carry_reg[5].lx * sin_p;
            ly_cp_reg <= carry_reg[5].ly * cos_p;
            ax_cw_reg <= carry_reg[5].ax * cos_w;
            ay_sw_reg <= carry_reg[5].ay * sin_w;
            ax_sw_reg <= carry_reg[5].ax * sin_w;
            ay_cw_reg <= carry_reg[5].ay * cos_w;
            px6_reg   <= carry_reg[5].px;
            py6_reg   <= carry_reg[5].py;
            wa6_reg   <= carry_reg[5].wa;
            wd6_reg   <= carry_reg[5].wd;
        end
    end

    // Stage 7: pair the products and round to nearest, ties up
    always_comb
    begin
        logic signed [65:0] sx0, sy0, sx1, sy1;
        sx0 = 66'(lx_cp_reg) - 66'(ly_sp_reg) + atc_pkg::Q30_HALF;
        sy0 = 66'(lx_sp_reg) + 66'(ly_cp_reg) + atc_pkg::Q30_HALF;
        sx1 = 66'(ax_cw_reg) - 66'(ay_sw_reg) + atc_pkg::Q30_HALF;
        sy1 = 66'(ax_sw_reg) + 66'(ay_cw_reg) + atc_pkg::Q30_HALF;
        ox_next = sx0[63:30];
        oy_next = sy0[63:30];
        nx_next = sx1[63:30];
        ny_next = sy1[63:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            px7_reg <= px6_reg;
            py7_reg <= py6_reg;
            wa7_reg <= wa6_reg;
            wd7_reg <= wd6_reg;
        end
    end

    // Stage 8: parent plus offset minus anchor, clamped once
    always_comb
    begin
        atc_pkg::wide_t xs, ys;
        xs = atc_pkg::wide_t'(px7_reg) + atc_pkg::wide_t'(ox_reg) - atc_pkg::wide_t'(nx_reg);
        ys = atc_pkg::wide_t'(py7_reg) + atc_pkg::wide_t'(oy_reg) - atc_pkg::wide_t'(ny_reg);
        wx_next = atc_pkg::sat_q16(xs);
        wy_next = atc_pkg::sat_q16(ys);
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            wa8_reg <= wa7_reg;
            wd8_reg <= wd7_reg;
        end
    end

    assign result.valid       = valid_reg[NS];
    assign result.world_x     = wx_reg;
    assign result.world_y     = wy_reg;
    assign result.world_angle = wa8_reg;
    assign result.world_depth = wd8_reg;

    // Count transactions in flight
    always_comb
    begin
        occ_next = occ_reg;
        if (item.valid && item.ready)
        begin
            occ_next = occ_next + 4'd1;
        end
        if (result.valid && result.ready)
        begin
            occ_next = occ_next - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Every transaction in flight sits in exactly one valid stage
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 4'($countones(valid_reg)))
    else $error("pipeline occupancy does not match transactions in flight");

    // A full pipe with a stalled output takes nothing new
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result.ready) |-> !item.ready)
    else $error("input accepted while pipe full and output stalled");

    // Sines and cosines stay within one in Q2.30
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |->
            (sin_p <= 32'sh4000_0000) && (sin_p >= -32'sh4000_0000) &&
            (cos_p <= 32'sh4000_0000) && (cos_p >= -32'sh4000_0000) &&
            (sin_w <= 32'sh4000_0000) && (sin_w >= -32'sh4000_0000) &&
            (cos_w <= 32'sh4000_0000) && (cos_w >= -32'sh4000_0000))
    else $error("sine pipeline result out of range");

    // A stalled product stage keeps its valid bit
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[6] && !adv[7]) |=> valid_reg[6])
    else $error("stalled product stage dropped its transaction");

endmodule
